>>> hdl/qrs_pkg.sv
// Shared widths, types and helpers for the quadratic root solver.
// No dependencies; imported by every module of the block.
package qrs_pkg;

  localparam int WORD_W   = 32;              // coefficient / root word
  localparam int FRAC_W   = 16;              // fraction bits
  localparam int TOL_W    = 16;              // tolerance register
  localparam int PROD_W   = 2 * WORD_W;      // magnitude products
  localparam int D_W      = PROD_W + 2;      // discriminant, even width
  localparam int SQ_W     = D_W / 2;         // square root bits
  localparam int SQ_REM_W = SQ_W + 2;        // root partial remainder
  localparam int NUM_W    = SQ_W + 1;        // numerator magnitude
  localparam int DEN_W    = WORD_W + 1;      // denominator magnitude (2|a|, or |b| if linear)
  localparam int DVD_W    = NUM_W + FRAC_W;  // scaled dividend / quotient

  localparam logic [DVD_W-1:0] SIGN_LIM =
    {{(DVD_W-WORD_W){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [DVD_W-1:0] MAX_LIM = SIGN_LIM - 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_ANY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DISC_NEG  = 2'd0,
    DISC_ZERO = 2'd1,
    DISC_POS  = 2'd2
  } disc_t;

  // sideband of one request while its discriminant is square-rooted
  typedef struct packed {
    logic                     valid;
    logic                     za;
    logic                     zb;
    logic                     zc;
    disc_t                    disc;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] c;
  } front_t;

  // sideband of one request while its roots are divided out
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  use_low;
    logic  use_high;
    logic  neg_low;
    logic  neg_high;
  } root_meta_t;

  function automatic logic [WORD_W-1:0] mag_w(input logic [WORD_W-1:0] v);
    mag_w = v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [NUM_W-1:0] mag_n(input logic [NUM_W+1:0] v);
    logic [NUM_W+1:0] t;
    t = v[NUM_W+1] ? (~v + 1'b1) : v;
    mag_n = t[NUM_W-1:0];
  endfunction

endpackage

>>> hdl/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: front stages, square root,
// root setup, two dividers, saturation and output skid. Uses qrs_pkg,
// qrs_front, qrs_sqrt and qrs_div.
//
// Usage:
//  - in_* carries one request per handshake: a, b, c as signed Q16.16.
//  - out_* returns one result per request, in order: two roots in tdata,
//    solution kind and saturation flag in tuser.
//  - cfg_we/cfg_wdata write the zero tolerance (raw units, reset 1); write
//    it only while no request is in flight.
//  - Throughput: one request per cycle while the receiver keeps out_tready high.
//  - Pipeline: 3 front stages, 33 square-root stages (one root bit each),
//    1 setup stage, 50 divider stages (one quotient bit each) and
//    1 saturation stage.
//  - Stall: while the receiver holds off, the result at the output moves
//    into a one-entry skid register and waits there, while the one behind
//    it fills the output register; only then does the pipeline freeze and
//    in_tready drop. Nothing is dropped or repeated.
//  - Reset (rst_n low, synchronous) empties the pipeline and the skid
//    register and sets the tolerance back to 1.
module quadratic_root_solver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,    // zero_tolerance
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,     // coef_a[31:0], coef_b[63:32], coef_c[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // root_low[31:0], root_high[63:32]
  output logic [2:0]  out_tuser     // solution_kind[1:0], saturated[2]
);
  import qrs_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic             en;

  front_t            fr_meta;
  logic [D_W-1:0]    fr_disc;
  logic [SQ_W-1:0]   sq_root;
  front_t            sq_meta_r [SQ_W];

  // root setup stage
  front_t            m;
  root_meta_t        rm_nxt, rm_r;
  logic [NUM_W-1:0]  num_low_nxt, num_high_nxt, num_low_r, num_high_r;
  logic [DEN_W-1:0]  den_nxt, den_r;
  logic [NUM_W+1:0]  b_ext, nb, s_ext, n_low, n_high;
  logic              a_neg, b_pos, c_pos;

  logic [DVD_W-1:0]  q_low, q_high;
  root_meta_t        dv_meta_r [DVD_W];
  root_meta_t        dm;

  // saturation stage
  logic [DVD_W-1:0]  lim_low, lim_high, val_low, val_high;
  logic              ovf_low, ovf_high;
  logic [WORD_W-1:0] r_low, r_high;

  logic              pv_r, sk_v_r;
  kind_t             p_kind_r, sk_kind_r;
  logic [WORD_W-1:0] p_low_r, p_high_r, sk_low_r, sk_high_r;
  logic              p_sat_r, sk_sat_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // whole pipeline advances unless the skid register is holding a result
  assign en        = !sk_v_r;
  assign in_tready = en;

  qrs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .coef_a   (in_tdata[31:0]),
    .coef_b   (in_tdata[63:32]),
    .coef_c   (in_tdata[95:64]),
    .tol      (tol_r),
    .meta     (fr_meta),
    .disc_mag (fr_disc)
  );

  qrs_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (fr_disc),
    .root (sq_root)
  );

  // sideband rides alongside the square root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ_W; i++) sq_meta_r[i] <= '0;
    end else if (en) begin
      sq_meta_r[0] <= fr_meta;
      for (int i = 1; i < SQ_W; i++) sq_meta_r[i] <= sq_meta_r[i-1];
    end
  end

  // ---------------------------------------------------------------- setup
  assign m      = sq_meta_r[SQ_W-1];
  assign b_ext  = {{(NUM_W+2-WORD_W){m.b[WORD_W-1]}}, m.b};
  assign nb     = ~b_ext + 1'b1;
  assign s_ext  = {{(NUM_W+2-SQ_W){1'b0}}, sq_root};
  assign n_low  = nb - s_ext;
  assign n_high = nb + s_ext;
  assign a_neg  = m.a[WORD_W-1];
  assign b_pos  = !m.b[WORD_W-1] && (m.b != '0);
  assign c_pos  = !m.c[WORD_W-1] && (m.c != '0);

  always_comb begin
    rm_nxt       = '0;
    rm_nxt.valid = m.valid;
    rm_nxt.kind  = KIND_NONE;
    num_low_nxt  = mag_n(n_low);
    num_high_nxt = mag_n(n_high);
    den_nxt      = {mag_w(m.a), 1'b0};
    if (m.za) begin
      // linear: b x + c = 0
      den_nxt = {1'b0, mag_w(m.b)};
      if (m.zb) begin
        rm_nxt.kind = m.zc ? KIND_ANY : KIND_NONE;
      end else begin
        rm_nxt.kind    = KIND_ONE;
        rm_nxt.use_low = 1'b1;
        rm_nxt.neg_low = c_pos != m.b[WORD_W-1];
        num_low_nxt    = {{(NUM_W-WORD_W){1'b0}}, mag_w(m.c)};
      end
    end else begin
      case (m.disc)
        DISC_ZERO: begin
          rm_nxt.kind    = KIND_ONE;
          rm_nxt.use_low = 1'b1;
          rm_nxt.neg_low = b_pos != a_neg;
          num_low_nxt    = {{(NUM_W-WORD_W){1'b0}}, mag_w(m.b)};
        end
        DISC_POS: begin
          rm_nxt.kind     = KIND_TWO;
          rm_nxt.use_low  = 1'b1;
          rm_nxt.use_high = 1'b1;
          rm_nxt.neg_low  = n_low[NUM_W+1] != a_neg;
          rm_nxt.neg_high = n_high[NUM_W+1] != a_neg;
        end
        default: begin
          rm_nxt.kind = KIND_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_r <= '0;
    end else if (en) begin
      rm_r <= rm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_low_r  <= num_low_nxt;
      num_high_r <= num_high_nxt;
      den_r      <= den_nxt;
    end
  end

  qrs_div u_div_low (
    .clk (clk),
    .en  (en),
    .num (num_low_r),
    .den (den_r),
    .quo (q_low)
  );

  qrs_div u_div_high (
    .clk (clk),
    .en  (en),
    .num (num_high_r),
    .den (den_r),
    .quo (q_high)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DVD_W; i++) dv_meta_r[i] <= '0;
    end else if (en) begin
      dv_meta_r[0] <= rm_r;
      for (int i = 1; i < DVD_W; i++) dv_meta_r[i] <= dv_meta_r[i-1];
    end
  end

  // ---------------------------------------------------------------- saturate
  assign dm       = dv_meta_r[DVD_W-1];
  assign lim_low  = dm.neg_low  ? SIGN_LIM : MAX_LIM;
  assign lim_high = dm.neg_high ? SIGN_LIM : MAX_LIM;
  assign ovf_low  = q_low  > lim_low;
  assign ovf_high = q_high > lim_high;
  assign val_low  = ovf_low  ? lim_low  : q_low;
  assign val_high = ovf_high ? lim_high : q_high;

  always_comb begin
    r_low  = '0;
    r_high = '0;
    if (dm.use_low) begin
      r_low = dm.neg_low ? (~val_low[WORD_W-1:0] + 1'b1) : val_low[WORD_W-1:0];
    end
    if (dm.use_high) begin
      r_high = dm.neg_high ? (~val_high[WORD_W-1:0] + 1'b1) : val_high[WORD_W-1:0];
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      if (en) begin
        pv_r <= dm.valid;
        if (pv_r && !out_tready) sk_v_r <= 1'b1;
      end else if (out_tready) begin
        sk_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_kind_r  <= dm.kind;
      p_low_r   <= r_low;
      p_high_r  <= r_high;
      p_sat_r   <= (dm.use_low && ovf_low) || (dm.use_high && ovf_high);
      sk_kind_r <= p_kind_r;
      sk_low_r  <= p_low_r;
      sk_high_r <= p_high_r;
      sk_sat_r  <= p_sat_r;
    end
  end

  assign out_tvalid = sk_v_r || pv_r;
  assign out_tdata  = sk_v_r ? {sk_high_r, sk_low_r} : {p_high_r, p_low_r};
  assign out_tuser  = sk_v_r ? {sk_sat_r, sk_kind_r} : {p_sat_r, p_kind_r};

endmodule

>>> hdl/qrs_front.sv
// Front stages: magnitudes and zero tests, the two products, discriminant.
// Depends on qrs_pkg.
module qrs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [qrs_pkg::WORD_W-1:0]    coef_a,
  input  logic signed [qrs_pkg::WORD_W-1:0]    coef_b,
  input  logic signed [qrs_pkg::WORD_W-1:0]    coef_c,
  input  logic        [qrs_pkg::TOL_W-1:0]     tol,
  output qrs_pkg::front_t                      meta,
  output logic        [qrs_pkg::D_W-1:0]       disc_mag
);
  import qrs_pkg::*;

  logic [WORD_W-1:0] ma_c, mb_c, mc_c, tol_ext;

  logic                     v0_r, v1_r, v2_r;
  logic signed [WORD_W-1:0] a0_r, b0_r, c0_r, a1_r, b1_r, c1_r;
  logic [WORD_W-1:0]        ma0_r, mb0_r, mc0_r;
  logic                     za0_r, zb0_r, zc0_r, za1_r, zb1_r, zc1_r;
  logic [PROD_W-1:0]        bb1_r, ac1_r;
  front_t                   m2_r, m2_nxt;
  logic [D_W-1:0]           d2_r, d2_nxt;

  logic [D_W-1:0] bb_ext, ac4;
  logic           opp;

  assign tol_ext = {{(WORD_W-TOL_W){1'b0}}, tol};
  assign ma_c    = mag_w(coef_a);
  assign mb_c    = mag_w(coef_b);
  assign mc_c    = mag_w(coef_c);

  // discriminant: exact b*b - 4ac from magnitudes and signs (b*b when it is negative)
  assign bb_ext = {2'b00, bb1_r};
  assign ac4    = {ac1_r, 2'b00};
  assign opp    = (a1_r[WORD_W-1] != c1_r[WORD_W-1]) && (c1_r != '0);

  always_comb begin
    m2_nxt       = '0;
    m2_nxt.valid = v1_r;
    m2_nxt.za    = za1_r;
    m2_nxt.zb    = zb1_r;
    m2_nxt.zc    = zc1_r;
    m2_nxt.a     = a1_r;
    m2_nxt.b     = b1_r;
    m2_nxt.c     = c1_r;
    if (opp) begin
      d2_nxt      = bb_ext + ac4;
      m2_nxt.disc = (d2_nxt != '0) ? DISC_POS : DISC_ZERO;
    end else if (bb_ext > ac4) begin
      d2_nxt      = bb_ext - ac4;
      m2_nxt.disc = DISC_POS;
    end else begin
      d2_nxt      = bb_ext;
      m2_nxt.disc = (bb_ext == ac4) ? DISC_ZERO : DISC_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= coef_a;
      b0_r  <= coef_b;
      c0_r  <= coef_c;
      ma0_r <= ma_c;
      mb0_r <= mb_c;
      mc0_r <= mc_c;
      za0_r <= ma_c <= tol_ext;
      zb0_r <= mb_c <= tol_ext;
      zc0_r <= mc_c <= tol_ext;
      a1_r  <= a0_r;
      b1_r  <= b0_r;
      c1_r  <= c0_r;
      za1_r <= za0_r;
      zb1_r <= zb0_r;
      zc1_r <= zc0_r;
      bb1_r <= mb0_r * mb0_r;
      ac1_r <= ma0_r * mc0_r;
      m2_r  <= m2_nxt;
      d2_r  <= d2_nxt;
    end
  end

  always_comb begin
    meta       = m2_r;
    meta.valid = v2_r;
  end
  assign disc_mag = d2_r;

endmodule

>>> hdl/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on qrs_pkg.
module qrs_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qrs_pkg::D_W-1:0]     rad,
  output logic [qrs_pkg::SQ_W-1:0]    root
);
  import qrs_pkg::*;

  logic [SQ_REM_W-1:0] rem_r  [SQ_W];
  logic [SQ_W-1:0]     root_r [SQ_W];
  logic [D_W-1:0]      rad_r  [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    logic [SQ_REM_W-1:0] in_rem, cur, trial;
    logic [SQ_W-1:0]     in_root;
    logic [D_W-1:0]      in_rad;
    logic                ge;

    if (k == 0) begin : g_first
      assign in_rem  = '0;
      assign in_root = '0;
      assign in_rad  = rad;
    end else begin : g_next
      assign in_rem  = rem_r[k-1];
      assign in_root = root_r[k-1];
      assign in_rad  = rad_r[k-1];
    end

    assign cur   = {in_rem[SQ_REM_W-3:0], in_rad[D_W-1 -: 2]};
    assign trial = {in_root, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (cur - trial) : cur;
        root_r[k] <= {in_root[SQ_W-2:0], ge};
        rad_r[k]  <= {in_rad[D_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQ_W-1];

endmodule

>>> hdl/qrs_div.sv
// Pipelined restoring divider: (num << FRAC_W) / den, one quotient bit per stage.
// Depends on qrs_pkg.
module qrs_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qrs_pkg::NUM_W-1:0]    num,
  input  logic [qrs_pkg::DEN_W-1:0]    den,
  output logic [qrs_pkg::DVD_W-1:0]    quo
);
  import qrs_pkg::*;

  // dvd_r shifts dividend bits out at the top and quotient bits in below
  logic [DEN_W-1:0] rem_r [DVD_W];
  logic [DVD_W-1:0] dvd_r [DVD_W];
  logic [DEN_W-1:0] den_r [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic [DEN_W-1:0] in_rem, in_den;
    logic [DVD_W-1:0] in_dvd;
    logic [DEN_W:0]   cur, diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign in_rem = '0;
      assign in_dvd = {num, {FRAC_W{1'b0}}};
      assign in_den = den;
    end else begin : g_next
      assign in_rem = rem_r[k-1];
      assign in_dvd = dvd_r[k-1];
      assign in_den = den_r[k-1];
    end

    assign cur  = {in_rem, in_dvd[DVD_W-1]};
    assign ge   = cur >= {1'b0, in_den};
    assign diff = cur - {1'b0, in_den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
        dvd_r[k] <= {in_dvd[DVD_W-2:0], ge};
        den_r[k] <= in_den;
      end
    end
  end

  assign quo = dvd_r[DVD_W-1];

endmodule

>>> tb/sv/tb_quadratic_root_solver_unit.sv
// Testbench for quadratic_root_solver_unit: random and directed coefficient sets,
// results checked against a behavioral solver in a small scoreboard class.
// Depends on qrs_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_quadratic_root_solver_unit;
  import qrs_pkg::*;

  typedef struct {
    kind_t            kind;
    logic [31:0]      root_low;
    logic [31:0]      root_high;
    logic             saturated;
  } solution_t;

  // Behavioral solver plus the queue of pending solutions.
  class root_scoreboard;
    solution_t pending[$];
    logic [15:0] tol;
    int errors;

    function new();
      tol = 16'd1;
      errors = 0;
    endfunction

    // (num << 16) / den truncated toward zero, clamped to 32-bit signed
    function automatic logic [31:0] quotient(input logic signed [127:0] num,
                                             input logic signed [127:0] den,
                                             inout logic sat);
      logic signed [127:0] q;
      q = (num <<< FRAC_W) / den;
      if (q > 128'sd2147483647) begin
        sat = 1'b1;
        q = 128'sd2147483647;
      end else if (q < -128'sd2147483648) begin
        sat = 1'b1;
        q = -128'sd2147483648;
      end
      return q[31:0];
    endfunction

    function automatic void note_request(input logic [95:0] coefs);
      logic signed [127:0] a, b, c, d, s, lo, hi;
      solution_t sol;
      logic sat;
      a = $signed(coefs[31:0]);
      b = $signed(coefs[63:32]);
      c = $signed(coefs[95:64]);
      sat = 1'b0;
      sol.root_low = '0;
      sol.root_high = '0;
      if ((a < 0 ? -a : a) <= tol) begin
        if ((b < 0 ? -b : b) <= tol) begin
          sol.kind = ((c < 0 ? -c : c) <= tol) ? KIND_ANY : KIND_NONE;
        end else begin
          sol.kind = KIND_ONE;
          sol.root_low = quotient(-c, b, sat);
        end
      end else begin
        d = b * b - 4 * a * c;
        if (d < 0) begin
          sol.kind = KIND_NONE;
        end else if (d == 0) begin
          sol.kind = KIND_ONE;
          sol.root_low = quotient(-b, 2 * a, sat);
        end else begin
          // bitwise floor square root
          s = 0;
          for (int i = 33; i >= 0; i--) begin
            lo = s | (128'sd1 <<< i);
            if (lo * lo <= d) s = lo;
          end
          sol.kind = KIND_TWO;
          sol.root_low = quotient(-b - s, 2 * a, sat);
          sol.root_high = quotient(-b + s, 2 * a, sat);
        end
      end
      sol.saturated = sat;
      pending.push_back(sol);
    endfunction

    function automatic void check_result(input logic [63:0] data, input logic [2:0] user);
      solution_t exp_sol;
      if (pending.size() == 0) begin
        $error("unexpected result tdata=%h tuser=%h", data, user);
        errors++;
        return;
      end
      exp_sol = pending.pop_front();
      if (user[1:0] !== exp_sol.kind) begin
        $error("solution_kind exp %0d got %0d", exp_sol.kind, user[1:0]);
        errors++;
      end
      if (data[31:0] !== exp_sol.root_low) begin
        $error("root_low exp %h got %h", exp_sol.root_low, data[31:0]);
        errors++;
      end
      if (data[63:32] !== exp_sol.root_high) begin
        $error("root_high exp %h got %h", exp_sol.root_high, data[63:32]);
        errors++;
      end
      if (user[2] !== exp_sol.saturated) begin
        $error("saturated exp %0d got %0d", exp_sol.saturated, user[2]);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY   = 88;
  localparam int CYCLE_CAP = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  root_scoreboard sb = new();
  int  cycle_count = 0;
  bit  hold_off = 1'b0;     // long receiver stall requested by stimulus

  always #1 clk = ~clk;

  quadratic_root_solver_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // cycle cap: a hang ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // sample requests and results at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      n = gap_len();
      if (n > 0 && ($urandom_range(0, 3) != 0)) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.tol = value;
  endtask

  // coefficient with a bias toward small and near-tolerance values
  function automatic logic [31:0] pick_coef(input logic [15:0] tol);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 2 * tol + 2)) - $signed({16'd0, tol}) - 1;
      2: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      4: return 32'(($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(1, 8))) <<< 16;
      default: return $urandom();
    endcase
  endfunction

  // a*(x-r1)*(x-r2) with small integer roots: exact discriminants
  task automatic send_factored();
    int r1, r2, k;
    r1 = $urandom_range(0, 20) - 10;
    r2 = $urandom_range(0, 1) ? r1 : $urandom_range(0, 20) - 10;
    k  = $urandom_range(1, 4) * ($urandom_range(0, 1) ? 1 : -1);
    send_request(32'(k) <<< 16, 32'(-k * (r1 + r2)) <<< 16, 32'(k * r1 * r2) <<< 16);
  endtask

  initial begin
    logic [15:0] tols[4];
    tols = '{16'd0, 16'd65535, 16'd300, 16'd1};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, linear/degenerate cases, each discriminant sign
    send_request(32'h0, 32'h0, 32'h0);                         // any x
    send_request(32'h1, 32'hFFFF_FFFF, 32'h1);                 // all within tolerance
    send_request(32'h0, 32'h0, 32'h0001_0000);                 // no solution
    send_request(32'h0, 32'h0002_0000, 32'hFFFC_0000);         // linear root 2
    send_request(32'h0, 32'h0000_0002, 32'h7FFF_FFFF);         // linear, saturates low
    send_request(32'h0, 32'hFFFF_FFFE, 32'h7FFF_FFFF);         // linear, saturates high
    send_request(32'h0001_0000, 32'h0, 32'h0001_0000);         // negative discriminant
    send_request(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000); // double root
    send_request(32'h0001_0000, 32'h0, 32'hFFFF_0000);         // roots +-1
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_request(32'h0000_0002, 32'h7FFF_FFFF, 32'h0);         // huge root, c zero
    send_request(32'hFFFF_FFFE, 32'h0, 32'h7FFF_FFFF);
    send_request(32'h0000_0002, 32'h0, 32'h8000_0000);
    send_request(32'hFFFF_0000, 32'h0, 32'h0);                 // double root at zero
    drain_and_idle();

    // random phases over several tolerance settings
    foreach (tols[t]) begin
      write_tolerance(tols[t]);
      for (int i = 0; i < 250; i++) begin
        if (t == 1 && i == 100) hold_off = 1'b1;   // block fills and stalls input
        if ($urandom_range(0, 2) == 0) send_factored();
        else send_request(pick_coef(tols[t]), pick_coef(tols[t]), pick_coef(tols[t]));
      end
      drain_and_idle();
    end

    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver_unit.sv
tb/sv/tb_quadratic_root_solver_unit.sv
